@@ src/baro_temp_pressure_compensation_top_defines.svh @@
// Assertion macros shared by the compensation block
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_TOP_DEFINES_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_TOP_DEFINES_SVH
// same-cycle implication
`define BARO_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("baro assertion failed");
// next-cycle implication
`define BARO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("baro assertion failed");
`endif

@@ src/baro_pkg.sv @@
// Types, constants and microprogram for barometer compensation
package baro_pkg;

  localparam int DataW = 64;
  localparam int CfgIdxW = 8;
  localparam int CfgDataW = 48;
  localparam int PcW = 5;

  localparam logic [CfgIdxW-1:0] REG_TEMP  = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_PA    = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_PB    = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_PC    = 8'd3;

  localparam logic MODE_TEMP  = 1'b0;
  localparam logic MODE_PRESS = 1'b1;

  typedef enum logic [4:0] {
    SRC_ONE, SRC_M256, SRC_U, SRC_T, SRC_D, SRC_TSQ, SRC_TCU, SRC_O, SRC_S,
    SRC_A, SRC_X, SRC_T1, SRC_T2, SRC_T3, SRC_P1, SRC_P2, SRC_P3, SRC_P4,
    SRC_P5, SRC_P6, SRC_P7, SRC_P8, SRC_P9, SRC_P10, SRC_P11
  } src_t;

  typedef enum logic [2:0] {
    DST_D, DST_TSQ, DST_TCU, DST_O, DST_S, DST_A, DST_X, DST_R
  } dst_t;

  typedef struct packed {
    src_t       a;
    src_t       b;
    dst_t       dst;
    logic [5:0] rs;
    logic [5:0] ls;
    logic       acc;
    logic       last;
  } uop_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } mul_ctl_t;

  // dst = (acc ? dst : 0) + (round(a*b >> rs) << ls)
  function automatic uop_t mk(input src_t a, input src_t b, input dst_t d,
                              input int rs, input int ls, input logic acc,
                              input logic last);
    uop_t u;
    u.a = a;
    u.b = b;
    u.dst = d;
    u.rs = 6'(rs);
    u.ls = 6'(ls);
    u.acc = acc;
    u.last = last;
    return u;
  endfunction

  function automatic uop_t uop_get(input logic mode, input logic [PcW-1:0] pc);
    uop_t u;
    u = mk(SRC_ONE, SRC_ONE, DST_R, 0, 0, 1'b0, 1'b1);
    if (mode == MODE_TEMP) begin
      case (pc)
        5'd0: u = mk(SRC_U,   SRC_ONE,  DST_D, 0,  0,  1'b0, 1'b0);
        5'd1: u = mk(SRC_T1,  SRC_M256, DST_D, 0,  0,  1'b1, 1'b0);
        5'd2: u = mk(SRC_D,   SRC_T2,   DST_X, 0,  18, 1'b0, 1'b0);
        5'd3: u = mk(SRC_D,   SRC_D,    DST_A, 0,  0,  1'b0, 1'b0);
        5'd4: u = mk(SRC_A,   SRC_T3,   DST_X, 0,  0,  1'b1, 1'b0);
        5'd5: u = mk(SRC_X,   SRC_ONE,  DST_R, 32, 0,  1'b0, 1'b1);
        default: u = mk(SRC_ONE, SRC_ONE, DST_R, 0, 0, 1'b0, 1'b1);
      endcase
    end else begin
      case (pc)
        5'd0:  u = mk(SRC_T,   SRC_T,   DST_TSQ, 16, 0,  1'b0, 1'b0);
        5'd1:  u = mk(SRC_TSQ, SRC_T,   DST_TCU, 16, 0,  1'b0, 1'b0);
        5'd2:  u = mk(SRC_P5,  SRC_ONE, DST_O,   0,  34, 1'b0, 1'b0);
        5'd3:  u = mk(SRC_P6,  SRC_T,   DST_O,   0,  9,  1'b1, 1'b0);
        5'd4:  u = mk(SRC_P7,  SRC_TSQ, DST_O,   0,  7,  1'b1, 1'b0);
        5'd5:  u = mk(SRC_P8,  SRC_TCU, DST_O,   0,  0,  1'b1, 1'b0);
        5'd6:  u = mk(SRC_P1,  SRC_ONE, DST_S,   0,  33, 1'b0, 1'b0);
        5'd7:  u = mk(SRC_P2,  SRC_T,   DST_S,   0,  8,  1'b1, 1'b0);
        5'd8:  u = mk(SRC_P3,  SRC_TSQ, DST_S,   0,  5,  1'b1, 1'b0);
        5'd9:  u = mk(SRC_P4,  SRC_TCU, DST_S,   0,  0,  1'b1, 1'b0);
        5'd10: u = mk(SRC_S,   SRC_ONE, DST_S,   19, 0,  1'b0, 1'b0);
        5'd11: u = mk(SRC_S,   SRC_U,   DST_O,   3,  0,  1'b1, 1'b0);
        5'd12: u = mk(SRC_P9,  SRC_ONE, DST_A,   0,  16, 1'b0, 1'b0);
        5'd13: u = mk(SRC_P10, SRC_T,   DST_A,   0,  0,  1'b1, 1'b0);
        5'd14: u = mk(SRC_A,   SRC_U,   DST_X,   24, 0,  1'b0, 1'b0);
        5'd15: u = mk(SRC_X,   SRC_U,   DST_X,   0,  0,  1'b0, 1'b0);
        5'd16: u = mk(SRC_U,   SRC_U,   DST_D,   0,  0,  1'b0, 1'b0);
        5'd17: u = mk(SRC_D,   SRC_P11, DST_D,   25, 0,  1'b0, 1'b0);
        5'd18: u = mk(SRC_D,   SRC_U,   DST_X,   0,  0,  1'b1, 1'b0);
        5'd19: u = mk(SRC_X,   SRC_ONE, DST_O,   9,  0,  1'b1, 1'b0);
        5'd20: u = mk(SRC_O,   SRC_ONE, DST_R,   23, 0,  1'b0, 1'b1);
        default: u = mk(SRC_ONE, SRC_ONE, DST_R, 0, 0, 1'b0, 1'b1);
      endcase
    end
    return u;
  endfunction

endpackage

@@ src/baro_in_if.sv @@
// Reading channel interface
interface baro_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [23:0] raw_reading;
  modport source (output valid, mode, raw_reading, input ready);
  modport sink (input valid, mode, raw_reading, output ready);
endinterface

@@ src/baro_out_if.sv @@
// Result channel interface
interface baro_out_if;
  logic               valid;
  logic               ready;
  logic signed [39:0] compensated_value;
  logic               value_kind;
  logic               saturated;
  modport source (output valid, compensated_value, value_kind, saturated, input ready);
  modport sink (input valid, compensated_value, value_kind, saturated, output ready);
endinterface

@@ src/baro_cfg_if.sv @@
// Configuration write channel interface
interface baro_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/baro_temp_pressure_compensation_top.sv @@
// Top level: barometer temperature and pressure compensation
//   channel | dir | payload
//   in_ch   | in  | mode, raw_reading
//   out_ch  | out | compensated_value, value_kind, saturated
//   cfg_ch  | in  | index, data (four calibration registers)
// One item runs a microprogram of 6 (temperature) or 21 (pressure) steps on a
// shared bit-serial multiplier; each step passes through issue, multiply until
// the multiplier signals done, and post, so the time from acceptance to a valid
// result depends on operand magnitudes.
// Synchronous active-low reset clears state, output valid, calibration registers and kept temperature.
// A finished result waits in the output register; the next item is accepted
// meanwhile and stalls only at its own completion.
`include "baro_temp_pressure_compensation_top_defines.svh"
module baro_temp_pressure_compensation_top
  import baro_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  baro_in_if.sink    in_ch,
  baro_out_if.source out_ch,
  baro_cfg_if.sink   cfg_ch
);
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_MUL   = 5'b00100,
    S_POST  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t           state_r;
  logic [39:0]      tc_r;
  logic [47:0]      pa_r, pb_r;
  logic [31:0]      pc_r;
  logic [31:0]      t_r;
  logic [23:0]      u_r;
  logic             mode_r;
  logic [PcW-1:0]   step_r;
  logic [DataW-1:0] d_r, tsq_r, tcu_r, o_r, s_r, a_r, x_r, r_r;
  logic             out_valid_r, out_kind_r, out_sat_r;
  logic             out_valid_nxt;
  logic [39:0]      out_val_r;

  uop_t             uop;
  mul_ctl_t         mul_ctl;
  logic [DataW-1:0] op_a, op_b, prod, rnd, val, dst_old, wr_val;
  logic             sat;

  assign uop = uop_get(mode_r, step_r);

  function automatic logic [DataW-1:0] sx8(input logic [7:0] v);
    return {{(DataW-8){v[7]}}, v};
  endfunction

  function automatic logic [DataW-1:0] sx16(input logic [15:0] v);
    return {{(DataW-16){v[15]}}, v};
  endfunction

  function automatic logic [DataW-1:0] src_val(input src_t s);
    logic [DataW-1:0] v;
    case (s)
      SRC_ONE:  v = 64'd1;
      SRC_M256: v = -64'sd256;
      SRC_U:    v = {40'd0, u_r};
      SRC_T:    v = {{32{t_r[31]}}, t_r};
      SRC_D:    v = d_r;
      SRC_TSQ:  v = tsq_r;
      SRC_TCU:  v = tcu_r;
      SRC_O:    v = o_r;
      SRC_S:    v = s_r;
      SRC_A:    v = a_r;
      SRC_X:    v = x_r;
      SRC_T1:   v = {48'd0, tc_r[15:0]};
      SRC_T2:   v = {48'd0, tc_r[31:16]};
      SRC_T3:   v = sx8(tc_r[39:32]);
      SRC_P1:   v = sx16(pa_r[15:0]) - 64'd16384;
      SRC_P2:   v = sx16(pa_r[31:16]) - 64'd16384;
      SRC_P3:   v = sx8(pa_r[39:32]);
      SRC_P4:   v = sx8(pa_r[47:40]);
      SRC_P5:   v = {48'd0, pb_r[15:0]};
      SRC_P6:   v = {48'd0, pb_r[31:16]};
      SRC_P7:   v = sx8(pb_r[39:32]);
      SRC_P8:   v = sx8(pb_r[47:40]);
      SRC_P9:   v = sx16(pc_r[15:0]);
      SRC_P10:  v = sx8(pc_r[23:16]);
      SRC_P11:  v = sx8(pc_r[31:24]);
      default:  v = '0;
    endcase
    return v;
  endfunction

  assign op_a = src_val(uop.a);
  assign op_b = src_val(uop.b);

  baro_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_ISSUE),
    .a     (op_a),
    .b     (op_b),
    .ctl   (mul_ctl),
    .prod  (prod)
  );

  always_comb begin
    if (uop.rs == 6'd0) begin
      rnd = prod;
    end else begin
      rnd = DataW'($signed(prod + (64'd1 << (uop.rs - 6'd1))) >>> uop.rs);
    end
    val = rnd << uop.ls;
    unique case (uop.dst)
      DST_D:   dst_old = d_r;
      DST_TSQ: dst_old = tsq_r;
      DST_TCU: dst_old = tcu_r;
      DST_O:   dst_old = o_r;
      DST_S:   dst_old = s_r;
      DST_A:   dst_old = a_r;
      DST_X:   dst_old = x_r;
      DST_R:   dst_old = r_r;
      default: dst_old = '0;
    endcase
    wr_val = (uop.acc ? dst_old : '0) + val;
  end

  assign sat = !((&r_r[DataW-1:39]) || !(|r_r[DataW-1:39]));

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tc_r        <= '0;
      pa_r        <= '0;
      pb_r        <= '0;
      pc_r        <= '0;
      t_r         <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.index)
          REG_TEMP: tc_r <= cfg_ch.data[39:0];
          REG_PA:   pa_r <= cfg_ch.data;
          REG_PB:   pb_r <= cfg_ch.data;
          REG_PC:   pc_r <= cfg_ch.data[31:0];
          default:  ;
        endcase
      end
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            step_r  <= '0;
            state_r <= S_ISSUE;
          end
        end
        S_ISSUE: state_r <= S_MUL;
        S_MUL: begin
          if (mul_ctl.done) begin
            state_r <= S_POST;
          end
        end
        S_POST: begin
          if (uop.last) begin
            state_r <= S_DONE;
          end else begin
            step_r  <= step_r + PcW'(1);
            state_r <= S_ISSUE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            if (mode_r == MODE_TEMP) begin
              t_r <= r_r[31:0];
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) begin
      u_r    <= in_ch.raw_reading;
      mode_r <= in_ch.mode;
    end
    if (state_r == S_POST) begin
      unique case (uop.dst)
        DST_D:   d_r   <= wr_val;
        DST_TSQ: tsq_r <= wr_val;
        DST_TCU: tcu_r <= wr_val;
        DST_O:   o_r   <= wr_val;
        DST_S:   s_r   <= wr_val;
        DST_A:   a_r   <= wr_val;
        DST_X:   x_r   <= wr_val;
        DST_R:   r_r   <= wr_val;
        default: ;
      endcase
    end
    if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) begin
      out_kind_r <= mode_r;
      out_sat_r  <= sat;
      out_val_r  <= sat ? (r_r[DataW-1] ? 40'h80_0000_0000 : 40'h7F_FFFF_FFFF) : r_r[39:0];
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.compensated_value = out_val_r;
  assign out_ch.value_kind        = out_kind_r;
  assign out_ch.saturated         = out_sat_r;

  `BARO_ASSERT_NEXT(a_accept_starts, in_ch.valid && in_ch.ready, state_r == S_ISSUE)
  `BARO_ASSERT_IMPL(a_done_in_mul, mul_ctl.done, state_r == S_MUL)
  `BARO_ASSERT_NEXT(a_issue_busy, state_r == S_ISSUE, mul_ctl.busy)
  `BARO_ASSERT_IMPL(a_rose_from_done, $rose(out_valid_r), $past(state_r == S_DONE))
endmodule

@@ src/baro_mul.sv @@
// Bit-serial 64-bit shift-add multiplier, product modulo 2^64
module baro_mul
  import baro_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DataW-1:0] a,
  input  logic [DataW-1:0] b,
  output mul_ctl_t         ctl,
  output logic [DataW-1:0] prod
);
  logic [DataW-1:0] mcand_r, mplier_r, acc_r, acc_nxt;
  logic [5:0]       cnt_r;
  logic             busy_r, done_r;

  assign acc_nxt = acc_r + (mplier_r[0] ? mcand_r : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63 || mplier_r[DataW-1:1] == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r  <= a;
      mplier_r <= b;
      acc_r    <= '0;
    end else if (busy_r) begin
      acc_r    <= acc_nxt;
      mcand_r  <= {mcand_r[DataW-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[DataW-1:1]};
    end
  end

  assign prod = acc_r;
  assign ctl.start = start;
  assign ctl.busy = busy_r;
  assign ctl.done = done_r;
endmodule

@@ tb/sv/baro_temp_pressure_compensation_top_test.sv @@
// Testbench: random and directed readings through the compensation block, checked per transaction
class baro_scoreboard;
  logic [39:0] temp_coef;
  logic [47:0] press_a;
  logic [47:0] press_b;
  logic [31:0] press_c;
  logic signed [31:0] kept_temp;
  logic [41:0] pending_results[$];
  int errors;
  int checked;

  function new();
    reset();
    errors = 0;
    checked = 0;
  endfunction

  function void reset();
    temp_coef = '0;
    press_a = '0;
    press_b = '0;
    press_c = '0;
    kept_temp = '0;
  endfunction

  function void write_reg(logic [7:0] idx, logic [47:0] data);
    case (idx)
      baro_pkg::REG_TEMP: temp_coef = data[39:0];
      baro_pkg::REG_PA:   press_a = data;
      baro_pkg::REG_PB:   press_b = data;
      baro_pkg::REG_PC:   press_c = data[31:0];
      default: ;
    endcase
  endfunction

  static function longint rshift(longint x, int n);
    longint h;
    h = longint'(1) <<< (n - 1);
    return (x + h) >>> n;
  endfunction

  function void note_reading(logic mode, logic [23:0] raw);
    longint u, d, num, res, t, tsq, tcu, o1, s, o2, a, o3;
    longint p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
    logic sat;
    sat = 1'b0;
    u = longint'(raw);
    if (mode == baro_pkg::MODE_TEMP) begin
      d = u - longint'(temp_coef[15:0]) * 256;
      num = d * longint'(temp_coef[31:16]) * 262144
            + d * d * longint'($signed(temp_coef[39:32]));
      res = rshift(num, 32);
      kept_temp = res[31:0];
    end else begin
      p1 = longint'($signed(press_a[15:0])) - 16384;
      p2 = longint'($signed(press_a[31:16])) - 16384;
      p3 = longint'($signed(press_a[39:32]));
      p4 = longint'($signed(press_a[47:40]));
      p5 = longint'(press_b[15:0]);
      p6 = longint'(press_b[31:16]);
      p7 = longint'($signed(press_b[39:32]));
      p8 = longint'($signed(press_b[47:40]));
      p9 = longint'($signed(press_c[15:0]));
      p10 = longint'($signed(press_c[23:16]));
      p11 = longint'($signed(press_c[31:24]));
      t = longint'(kept_temp);
      tsq = rshift(t * t, 16);
      tcu = rshift(tsq * t, 16);
      o1 = (p5 <<< 34) + p6 * t * 512 + p7 * tsq * 128 + p8 * tcu;
      s = (p1 <<< 33) + p2 * t * 256 + p3 * tsq * 32 + p4 * tcu;
      o2 = rshift(u * rshift(s, 19), 3);
      a = p9 * 65536 + p10 * t;
      o3 = rshift(rshift(u * a, 24) * u + rshift(u * u * p11, 25) * u, 9);
      res = rshift(o1 + o2 + o3, 23);
    end
    if (res > 64'sd549755813887) begin
      res = 64'sd549755813887;
      sat = 1'b1;
    end
    if (res < -64'sd549755813888) begin
      res = -64'sd549755813888;
      sat = 1'b1;
    end
    pending_results.push_back({res[39:0], mode, sat});
  endfunction

  function void check_result(logic [39:0] val, logic kind, logic sat);
    logic [41:0] exp_r;
    checked++;
    if (pending_results.size() == 0) begin
      $error("unexpected result transaction value=%0h", val);
      errors++;
      return;
    end
    exp_r = pending_results.pop_front();
    if (exp_r[41:2] !== val) begin
      $error("compensated_value expected %0d actual %0d",
             $signed(exp_r[41:2]), $signed(val));
      errors++;
    end
    if (exp_r[1] !== kind) begin
      $error("value_kind expected %0d actual %0d", exp_r[1], kind);
      errors++;
    end
    if (exp_r[0] !== sat) begin
      $error("saturated expected %0d actual %0d", exp_r[0], sat);
      errors++;
    end
  endfunction
endclass

module baro_temp_pressure_compensation_top_test;
  import baro_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  baro_in_if in_ch();
  baro_out_if out_ch();
  baro_cfg_if cfg_ch();
  baro_scoreboard board;
  longint cycles = 0;
  bit hold_off = 1'b0;
  int n_temp = 0;
  int n_press = 0;

  baro_temp_pressure_compensation_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.raw_reading = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd20000000) begin
      $display("FAIL baro_temp_pressure_compensation_top");
      $finish;
    end
  end

  task automatic write_cfg(logic [7:0] idx, logic [47:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    board.write_reg(idx, data);
  endtask

  task automatic send_reading(logic mode, logic [23:0] raw, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.raw_reading <= raw;
    do @(posedge clk); while (!in_ch.ready);
    board.note_reading(mode, raw);
    if (mode == MODE_TEMP) n_temp++;
    else n_press++;
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      board.check_result(out_ch.compensated_value, out_ch.value_kind,
                         out_ch.saturated);
    end
  end

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  task automatic load_all(logic [39:0] tc, logic [47:0] pa, logic [47:0] pb,
                          logic [31:0] pc);
    write_cfg(REG_TEMP, {8'h0, tc});
    write_cfg(REG_PA, pa);
    write_cfg(REG_PB, pb);
    write_cfg(REG_PC, {16'h0, pc});
    write_cfg(8'd200, 48'($urandom()));
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [23:0] rand_raw();
    case ($urandom_range(0, 3))
      0: return 24'($urandom());
      1: return 24'h7FFFFF + 24'($urandom_range(0, 65535)) - 24'd32768;
      2: return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
      default: return 24'h600000 + 24'($urandom_range(0, 24'h1FFFFF));
    endcase
  endfunction

  initial begin
    bit gaps;
    board = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // pressure with kept temperature still zero
    send_reading(MODE_PRESS, 24'h123456, 1'b0);
    send_reading(MODE_PRESS, 24'hFFFFFF, 1'b0);
    drain();
    load_all(40'hFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_reading(MODE_TEMP, 24'h000000, 1'b0);
    send_reading(MODE_PRESS, 24'hFFFFFF, 1'b0);
    send_reading(MODE_TEMP, 24'hFFFFFF, 1'b0);
    send_reading(MODE_PRESS, 24'h000000, 1'b0);
    drain();
    load_all(40'h80_FFFF_0000, 48'h80_7F_8000_7FFF, 48'h7F_80_0000_FFFF, 32'h807F_8000);
    send_reading(MODE_TEMP, 24'hFFFFFF, 1'b0);
    send_reading(MODE_PRESS, 24'hFFFFFF, 1'b0);
    send_reading(MODE_TEMP, 24'h000000, 1'b0);
    send_reading(MODE_PRESS, 24'h800000, 1'b0);
    drain();
    load_all(40'h7F_0000_FFFF, 48'h7F_80_7FFF_8000, 48'h80_7F_FFFF_0000, 32'h7F80_7FFF);
    send_reading(MODE_TEMP, 24'hFFFFFF, 1'b0);
    send_reading(MODE_PRESS, 24'hFFFFFF, 1'b0);
    send_reading(MODE_TEMP, 24'h800000, 1'b0);
    send_reading(MODE_PRESS, 24'h000001, 1'b0);
    drain();
    // random calibration, random content, block filled by a long hold-off
    for (int ph = 0; ph < 8; ph++) begin
      load_all({$urandom(), $urandom()}, {$urandom(), $urandom()},
               {$urandom(), $urandom()}, $urandom());
      if (ph == 1) hold_off = 1'b1;
      for (int i = 0; i < 240; i++) begin
        gaps = (i % 60) >= 20;
        send_reading(($urandom_range(0, 2) != 0), rand_raw(), gaps);
      end
      drain();
    end
    if (board.pending_results.size() != 0) begin
      $error("%0d expected results never arrived", board.pending_results.size());
      board.errors++;
    end
    $display("Covered %0d temperature and %0d pressure readings, %0d results checked,",
             n_temp, n_press, board.checked);
    $display("across reset, extreme and random calibration settings.");
    if (board.errors == 0) begin
      $display("PASS baro_temp_pressure_compensation_top");
    end else begin
      $display("FAIL baro_temp_pressure_compensation_top");
    end
    $finish;
  end
endmodule
